// ----- rtl/core/uss_pkg.sv -----
// Shared types and constants for the UTF-8 surrogate sanitizer.
package uss_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  typedef logic [7:0] byte_t;

  // Sequence lengths claimed by a lead byte.
  localparam logic [2:0] SeqLen2 = 3'd2;
  localparam logic [2:0] SeqLen3 = 3'd3;
  localparam logic [2:0] SeqLen4 = 3'd4;

  // U+FFFD in UTF-8, first byte out in slot 0.
  localparam logic [3:0][7:0] ReplBytes = {8'h00, 8'hBD, 8'hBF, 8'hEF};
  localparam logic [1:0]      ReplLast  = 2'd2;

  // One unit of work handed from the front to the back: up to four bytes.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            eos;
  } job_t;

  typedef struct packed {
    byte_t out_byte;
    logic  run_last;
    logic  string_done;
  } out_beat_t;

endpackage

// ----- rtl/core/uss_in_if.sv -----
// Input channel: one raw string byte per beat.
interface uss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

// ----- rtl/core/uss_out_if.sv -----
// Output channel: one cleaned byte per beat.
interface uss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_done;

  modport source (output valid, output out_byte, output run_last, output string_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input string_done,
                  output ready);
endinterface

// ----- rtl/core/uss_front.sv -----
// Front end: decodes input bytes, tracks the open sequence, builds output jobs.
module uss_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  uss_pkg::byte_t in_byte_i,
  input  logic          eos_i,
  output logic          in_ready_o,
  input  logic          q_full_i,
  output logic          push_o,
  output uss_pkg::job_t job_o
);
  import uss_pkg::*;

  logic [23:0] held_q, held_d;
  logic [1:0]  pend_q, pend_d;
  logic [2:0]  seqlen_q, seqlen_d;
  logic        good_q, good_d;

  logic        fire;
  logic        has_out;
  logic [2:0]  lead_len;
  logic [1:0]  pend_n;
  logic        good_n;
  logic        pass;

  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && in_ready_o;
  assign push_o     = fire && has_out;

  always_comb begin
    held_d   = held_q;
    pend_d   = pend_q;
    seqlen_d = seqlen_q;
    good_d   = good_q;
    has_out  = 1'b0;
    lead_len = 3'd0;
    pend_n   = pend_q - 2'd1;
    good_n   = good_q && (in_byte_i[7:6] == 2'b10);
    pass     = 1'b0;
    job_o    = '{bytes: '0, last_idx: 2'd0, eos: eos_i};

    if (pend_q == 2'd0) begin
      if (!in_byte_i[7]) begin
        has_out        = 1'b1;
        job_o.bytes[0] = in_byte_i;
      end else if (in_byte_i[7:5] == 3'b110) begin
        lead_len = SeqLen2;
      end else if (in_byte_i[7:4] == 4'b1110) begin
        lead_len = SeqLen3;
      end else if (in_byte_i[7:3] == 5'b11110) begin
        lead_len = SeqLen4;
      end else begin
        has_out        = 1'b1;
        job_o.bytes    = ReplBytes;
        job_o.last_idx = ReplLast;
      end

      if (lead_len != 3'd0) begin
        if (eos_i) begin
          // String ends right on a lead byte.
          has_out        = 1'b1;
          job_o.bytes    = ReplBytes;
          job_o.last_idx = ReplLast;
        end else begin
          held_d   = {16'h0000, in_byte_i};
          pend_d   = lead_len[1:0] - 2'd1;
          seqlen_d = lead_len;
          good_d   = 1'b1;
        end
      end
    end else if (pend_n == 2'd0) begin
      // Sequence complete: pass it or replace it as a whole.
      pass = good_n;
      if (seqlen_q == SeqLen3 && held_q[11:8] == 4'hD && held_q[5]) begin
        pass = 1'b0;
      end
      has_out = 1'b1;
      if (pass) begin
        case (seqlen_q)
          SeqLen2: begin
            job_o.bytes[0] = held_q[7:0];
            job_o.bytes[1] = in_byte_i;
            job_o.last_idx = 2'd1;
          end
          SeqLen3: begin
            job_o.bytes[0] = held_q[15:8];
            job_o.bytes[1] = held_q[7:0];
            job_o.bytes[2] = in_byte_i;
            job_o.last_idx = 2'd2;
          end
          SeqLen4: begin
            job_o.bytes[0] = held_q[23:16];
            job_o.bytes[1] = held_q[15:8];
            job_o.bytes[2] = held_q[7:0];
            job_o.bytes[3] = in_byte_i;
            job_o.last_idx = 2'd3;
          end
          default: begin
            job_o.bytes[0] = in_byte_i;
          end
        endcase
      end else begin
        job_o.bytes    = ReplBytes;
        job_o.last_idx = ReplLast;
      end
      held_d   = '0;
      pend_d   = 2'd0;
      seqlen_d = 3'd0;
      good_d   = 1'b1;
    end else if (eos_i) begin
      // String cut short inside a sequence.
      has_out        = 1'b1;
      job_o.bytes    = ReplBytes;
      job_o.last_idx = ReplLast;
      held_d         = '0;
      pend_d         = 2'd0;
      seqlen_d       = 3'd0;
      good_d         = 1'b1;
    end else begin
      held_d = {held_q[15:0], in_byte_i};
      pend_d = pend_n;
      good_d = good_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= '0;
      pend_q   <= 2'd0;
      seqlen_q <= 3'd0;
      good_q   <= 1'b1;
    end else if (fire) begin
      held_q   <= held_d;
      pend_q   <= pend_d;
      seqlen_q <= seqlen_d;
      good_q   <= good_d;
    end
  end

endmodule

// ----- rtl/core/uss_queue.sv -----
// Short job queue between front and back.
module uss_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  uss_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output uss_pkg::job_t data_o
);
  import uss_pkg::*;

  job_t             mem_q [QDepth];
  logic [QAw-1:0]   wptr_q, rptr_q;
  logic [QAw:0]     cnt_q;

  assign full_o  = (cnt_q == (QAw+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/uss_back.sv -----
// Back end: serializes each job into output beats, one byte per beat.
module uss_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  uss_pkg::job_t      job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output uss_pkg::out_beat_t out_o
);
  import uss_pkg::*;

  job_t       cur_q;
  logic       cur_valid_q;
  logic [1:0] idx_q;

  logic fire;
  logic last;
  logic done;

  assign last  = (idx_q == cur_q.last_idx);
  assign fire  = cur_valid_q && out_ready_i;
  assign done  = fire && last;
  assign pop_o = job_valid_i && (!cur_valid_q || done);

  assign out_valid_o       = cur_valid_q;
  assign out_o.out_byte    = cur_q.bytes[idx_q];
  assign out_o.run_last    = last;
  assign out_o.string_done = last && cur_q.eos;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else if (pop_o) begin
      cur_valid_q <= 1'b1;
      idx_q       <= 2'd0;
    end else if (done) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else if (fire) begin
      idx_q <= idx_q + 2'd1;
    end
  end

endmodule

// ----- rtl/core/utf8_surrogate_sanitizer.sv -----
// UTF-8 sanitizer top level: front decoder, job queue, output serializer.
//
// Input channel in_i: one raw string byte per beat, end_of_string set on the
// final byte of a string. Output channel out_o: one cleaned byte per beat.
// Plain ASCII passes through. A valid 2, 3 or 4 byte sequence is released
// in one burst when its last byte arrives; a broken sequence, a stray lead or
// continuation byte, a 3-byte surrogate or a string cut short becomes the
// three bytes EF BF BD. run_last marks the last output beat caused by one
// input beat; string_done marks the final output beat of a string.
//
// Throughput: one input beat per cycle while the job queue has room and one
// output beat per cycle while out_o.ready is high. An input beat that
// expands to N output bytes occupies the output for N beats; the four-entry
// job queue absorbs the difference, and in_i.ready drops only when that
// queue is full. With the serializer idle, the queue takes the job at the
// accepting edge, then the serializer loads it into its own register, which
// drives the first output byte.
// Reset: clears the open sequence, empties the queue and drops out_o.valid.
// Receiver stall: the current output beat holds; the front keeps taking
// input until the queue fills.
module utf8_surrogate_sanitizer (
  input  logic    clk_i,
  input  logic    rst_ni,
  uss_in_if.sink  in_i,
  uss_out_if.source out_o
);
  import uss_pkg::*;

  job_t      fr_job;
  job_t      q_job;
  logic      fr_push;
  logic      q_full;
  logic      q_empty;
  logic      bk_pop;
  out_beat_t bk_beat;

  // Decode bytes and build jobs.
  uss_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_byte_i  (in_i.in_byte),
    .eos_i      (in_i.end_of_string),
    .in_ready_o (in_i.ready),
    .q_full_i   (q_full),
    .push_o     (fr_push),
    .job_o      (fr_job)
  );

  // Buffer jobs so the front keeps running while replacements drain.
  uss_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .data_i  (fr_job),
    .full_o  (q_full),
    .pop_i   (bk_pop),
    .empty_o (q_empty),
    .data_o  (q_job)
  );

  // Serialize jobs onto the output channel.
  uss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!q_empty),
    .job_i       (q_job),
    .pop_o       (bk_pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_o       (bk_beat)
  );

  assign out_o.out_byte    = bk_beat.out_byte;
  assign out_o.run_last    = bk_beat.run_last;
  assign out_o.string_done = bk_beat.string_done;

endmodule

// ----- rtl/core/uss_checker.sv -----
// Port-level checks for the UTF-8 sanitizer, bound to the top level.
module uss_port_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       run_last_i,
  input logic       string_done_i
);

  // End of string always closes the burst of its input beat.
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && string_done_i |-> run_last_i)
    else $error("string_done without run_last");

  // Bytes below 0x80 only come from single-byte pass-through.
  a_ascii_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_byte_i[7] |-> run_last_i)
    else $error("ASCII byte inside a multi-byte burst");

  // A burst, once started, continues without a gap.
  a_burst_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !run_last_i |=> out_valid_i)
    else $error("gap inside an output burst");

  // Hold a stalled beat.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
      && $stable(run_last_i) && $stable(string_done_i))
    else $error("stalled output beat changed");

endmodule

bind utf8_surrogate_sanitizer uss_port_checker u_uss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_byte_i    (out_o.out_byte),
  .run_last_i    (out_o.run_last),
  .string_done_i (out_o.string_done)
);

// ----- verif/uss_checker.sv -----
// Scoreboard for the UTF-8 sanitizer: predicts cleaned bytes and checks every output beat.
module uss_checker
  import uss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  uss_in_if           in_i,
  uss_out_if          out_i,
  output int unsigned fail_cnt_o,
  output int unsigned exp_left_o,
  output int unsigned beats_seen_o
);

  localparam int unsigned ReportMax = 10;
  localparam logic [15:0] SurrLo    = 16'hD800;
  localparam logic [15:0] SurrHi    = 16'hDFFF;

  out_beat_t   exp_beats_q[$];
  byte_t       step_bytes[$];

  // Open multi-byte sequence.
  logic [23:0] seq_held;
  logic [1:0]  seq_left;
  logic [2:0]  seq_len;
  logic        cont_ok;

  function automatic void close_sequence();
    seq_held = '0;
    seq_left = '0;
    seq_len  = '0;
    cont_ok  = 1'b1;
  endfunction

  function automatic void push_replacement();
    int k;
    for (k = 0; k <= int'(ReplLast); k++) step_bytes.push_back(ReplBytes[k]);
  endfunction

  // Work out the cleaned bytes one raw byte causes and queue them as beats.
  function automatic void predict_clean_bytes(input byte_t b, input logic eos);
    logic [2:0]  len;
    logic        pass;
    logic [15:0] cp;
    int          nheld;
    int          k;
    out_beat_t   beat;
    len = '0;
    step_bytes.delete();
    if (seq_left == 2'd0) begin
      if (b < 8'h80) step_bytes.push_back(b);
      else if ((b & 8'hE0) == 8'hC0) len = SeqLen2;
      else if ((b & 8'hF0) == 8'hE0) len = SeqLen3;
      else if ((b & 8'hF8) == 8'hF0) len = SeqLen4;
      else push_replacement();
      if (len != '0) begin
        if (eos) begin
          push_replacement();
          close_sequence();
        end else begin
          seq_held = {16'h0000, b};
          seq_left = 2'(len - 3'd1);
          seq_len  = len;
          cont_ok  = 1'b1;
        end
      end
    end else begin
      if ((b & 8'hC0) != 8'h80) cont_ok = 1'b0;
      seq_left = seq_left - 2'd1;
      if (seq_left == 2'd0) begin
        pass  = cont_ok;
        nheld = int'(seq_len) - 1;
        if (pass && seq_len == SeqLen3) begin
          cp = {seq_held[11:8], seq_held[5:0], b[5:0]};
          if (cp >= SurrLo && cp <= SurrHi) pass = 1'b0;
        end
        if (pass) begin
          for (k = nheld - 1; k >= 0; k--) step_bytes.push_back(seq_held[k*8 +: 8]);
          step_bytes.push_back(b);
        end else begin
          push_replacement();
        end
        close_sequence();
      end else if (eos) begin
        push_replacement();
        close_sequence();
      end else begin
        seq_held = {seq_held[15:0], b};
      end
    end
    for (k = 0; k < step_bytes.size(); k++) begin
      beat.out_byte    = step_bytes[k];
      beat.run_last    = (k == step_bytes.size() - 1);
      beat.string_done = eos && beat.run_last;
      exp_beats_q.push_back(beat);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      close_sequence();
      exp_beats_q.delete();
      fail_cnt_o   = 0;
      exp_left_o   = 0;
      beats_seen_o = 0;
    end else begin
      if (in_i.valid && in_i.ready) predict_clean_bytes(in_i.in_byte, in_i.end_of_string);
      if (out_i.valid && out_i.ready) begin
        beats_seen_o++;
        if (exp_beats_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= ReportMax)
            $display("unexpected beat %0d: byte %h last %b done %b", beats_seen_o,
                     out_i.out_byte, out_i.run_last, out_i.string_done);
        end else begin
          want = exp_beats_q.pop_front();
          if (out_i.out_byte !== want.out_byte || out_i.run_last !== want.run_last ||
              out_i.string_done !== want.string_done) begin
            fail_cnt_o++;
            if (fail_cnt_o <= ReportMax)
              $display("beat %0d: expected byte %h last %b done %b, got byte %h last %b done %b",
                       beats_seen_o, want.out_byte, want.run_last, want.string_done,
                       out_i.out_byte, out_i.run_last, out_i.string_done);
          end
        end
      end
      exp_left_o = exp_beats_q.size();
    end
  end

endmodule

// ----- verif/tb_top.sv -----
// Top of the UTF-8 sanitizer testbench: clock, reset, byte stimulus and verdict.
module tb_top;
  import uss_pkg::*;

  localparam int unsigned HalfPeriod  = 5;
  localparam int unsigned ResetCycles = 6;
  localparam int unsigned RandItems   = 405;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned IdleLimit   = 5000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned NumPhases   = 4;

  // Idle mixes, in percent: none, sender idle, receiver stalling, both a little.
  localparam int unsigned SendIdle [NumPhases] = '{0, 87, 0, 10};
  localparam int unsigned RecvStall[NumPhases] = '{0, 0, 87, 10};

  // Directed strings, {end_of_string, byte}: NUL and 7F, valid 2/3/4 byte forms,
  // a surrogate and the value just below the surrogate range, stray lead and
  // continuation bytes, a broken continuation, and strings cut short both on
  // the lead byte and inside a sequence.
  localparam logic [8:0] Directed[25] = '{
    9'h000, 9'h17F,
    9'h0C3, 9'h0A9,
    9'h0E2, 9'h082, 9'h0AC,
    9'h0F0, 9'h09F, 9'h098, 9'h180,
    9'h0ED, 9'h0A0, 9'h080,
    9'h0ED, 9'h09F, 9'h0BF,
    9'h080, 9'h0F8, 9'h0FF,
    9'h0C3, 9'h041,
    9'h1E2,
    9'h0E2, 9'h182
  };

  logic        clk_i;
  logic        rst_ni;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_req;
  int unsigned bytes_sent;
  int unsigned strings_sent;
  int unsigned idle_cycles;
  int unsigned fail_cnt;
  int unsigned exp_left;
  int unsigned beats_seen;

  uss_in_if  in_ch ();
  uss_out_if out_ch ();

  utf8_surrogate_sanitizer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  uss_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .fail_cnt_o   (fail_cnt),
    .exp_left_o   (exp_left),
    .beats_seen_o (beats_seen)
  );

  initial clk_i = 1'b0;
  always #HalfPeriod clk_i = ~clk_i;

  // Offer one byte, idling first at the current rate; hold it until accepted.
  // Valid stays high on return so back-to-back bytes never drop it.
  task automatic send_byte(input byte_t b, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.in_byte       <= b;
    in_ch.end_of_string <= eos;
    do @(posedge clk_i); while (!in_ch.ready);
    bytes_sent++;
    if (eos) strings_sent++;
    @(negedge clk_i);
  endtask

  // Build one sequence: mostly well-formed with random payload bits, some
  // surrogate-range 3-byte forms, some raw noise, and now and then one
  // following byte overwritten so the sequence breaks.
  task automatic send_random_sequence();
    byte_t       seq[4];
    int unsigned n;
    int unsigned kind;
    int unsigned k;
    logic        eos;
    n    = 1;
    kind = $urandom_range(99);
    if (kind < 30) begin
      seq[0] = 8'($urandom_range(127));
    end else if (kind < 45) begin
      n      = 2;
      seq[0] = {3'b110, 5'($urandom)};
    end else if (kind < 62) begin
      n      = 3;
      seq[0] = {4'b1110, 4'($urandom)};
    end else if (kind < 77) begin
      n      = 4;
      seq[0] = {5'b11110, 3'($urandom)};
    end else if (kind < 87) begin
      // ED lead: bit 5 of the first continuation picks surrogate or not
      n      = 3;
      seq[0] = 8'hED;
    end else begin
      seq[0] = 8'($urandom);
    end
    for (k = 1; k < n; k++) seq[k] = {2'b10, 6'($urandom)};
    if (n > 1 && $urandom_range(9) == 0) seq[$urandom_range(n - 1, 1)] = 8'($urandom);
    for (k = 0; k < n; k++) begin
      // end strings mostly on sequence boundaries, sometimes mid-sequence
      eos = (k == n - 1) ? ($urandom_range(7) == 0) : ($urandom_range(39) == 0);
      send_byte(seq[k], eos);
    end
  endtask

  // Drop valid and hold off until every predicted beat has come out.
  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (exp_left != 0);
  endtask

  // Receiver: stall at the current rate; on request hold ready low for a long
  // stretch so the job queue fills and input backs up.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no beat for %0d cycles, %0d beats still expected",
               idle_cycles, exp_left);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned start_cnt;
    int unsigned i;
    in_ch.valid         = 1'b0;
    in_ch.in_byte       = '0;
    in_ch.end_of_string = 1'b0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    hold_req            = 1'b0;
    bytes_sent          = 0;
    strings_sent        = 0;
    idle_cycles         = 0;
    rst_ni              = 1'b0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed strings, back to back.
    for (i = 0; i < $size(Directed); i++) send_byte(Directed[i][7:0], Directed[i][8]);
    pause_until_drained();

    // Random sequences, one idle mix per phase; drain between phases.
    for (phase = 0; phase < NumPhases; phase++) begin
      send_idle_pct  = SendIdle[phase];
      recv_stall_pct = RecvStall[phase];
      if (phase == 0) hold_req = 1'b1;
      start_cnt = bytes_sent;
      while (bytes_sent - start_cnt < RandItems / NumPhases) send_random_sequence();
      pause_until_drained();
    end

    // Let any trailing beats settle, then give the verdict.
    recv_stall_pct = 0;
    pause_until_drained();
    repeat (DrainCycles) @(negedge clk_i);

    $display("Sent %0d bytes in %0d strings, checked %0d output beats;", bytes_sent,
             strings_sent, beats_seen);
    $display("four idle mixes, one long output hold and a full drain between phases.");
    if (exp_left != 0) $display("%0d expected beats never arrived", exp_left);
    if (fail_cnt == 0 && exp_left == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- utf8_surrogate_sanitizer.f -----
rtl/core/uss_pkg.sv
rtl/core/uss_in_if.sv
rtl/core/uss_out_if.sv
rtl/core/uss_front.sv
rtl/core/uss_queue.sv
rtl/core/uss_back.sv
rtl/core/utf8_surrogate_sanitizer.sv
rtl/core/uss_checker.sv
verif/uss_checker.sv
verif/tb_top.sv
